>>> rtl/baro_sensor_compensation_top_defines.svh
// Assertion macros shared by the RTL of the barometric compensation block.
// Define ASSERT_OFF to compile every check away.
`ifndef BARO_SENSOR_COMPENSATION_TOP_DEFINES_SVH
`define BARO_SENSOR_COMPENSATION_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Antecedent holds in the same cycle as the consequent.
`define BSC_ASSERT_IMPLY(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BSC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define BSC_ASSERT_IMPLY(lbl, clk, rst_n, pre, post, msg)
`define BSC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

>>> rtl/bsc_pkg.sv
package bsc_pkg;

    localparam int NUM_STAGES = 9;
    localparam int RAW_W      = 24;
    localparam int CAL_W      = 16;
    localparam int REG_IDX_W  = 3;
    localparam int TEMP_OUT_W = 14;
    localparam int PRES_OUT_W = 17;

    // Register indexes on the configuration port
    localparam logic [REG_IDX_W-1:0] REG_C1_SENS     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_C2_OFF      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_C3_TCS      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_C4_TCO      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_C5_TREF     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_C6_TEMPSENS = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TEMP_OFFSET = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_PRES_OFFSET = 3'd7;

    localparam int PRES_OFFSET_RESET = 170;

    // Compensation constants, temperatures in 0.01 C, pressures in 0.01 hPa
    localparam int T_REF_CENTI    = 2000;
    localparam int T_VLO_CENTI    = -1500;
    localparam int OFF2_SQ_GAIN   = 61;
    localparam int OFF2_SQ_SHIFT  = 4;
    localparam int OFF2_VLO_GAIN  = 15;
    localparam int SENS2_SQ_GAIN  = 2;
    localparam int SENS2_VLO_GAIN = 8;
    localparam int T_MIN_CENTI    = -3000;
    localparam int T_MAX_CENTI    = 8000;
    localparam int P_MIN_CENTI    = 30000;
    localparam int P_MAX_CENTI    = 120000;

    typedef struct packed {
        logic        [CAL_W-1:0] c1;
        logic        [CAL_W-1:0] c2;
        logic        [CAL_W-1:0] c3;
        logic        [CAL_W-1:0] c4;
        logic        [CAL_W-1:0] c5;
        logic        [CAL_W-1:0] c6;
        logic signed [CAL_W-1:0] t_off;
        logic signed [CAL_W-1:0] p_off;
    } cal_t;

    typedef struct packed {
        logic signed [TEMP_OUT_W-1:0] temp_centi;
        logic        [PRES_OUT_W-1:0] pressure_centi;
        logic                         in_range;
    } res_t;

endpackage

>>> rtl/bsc_pipe.sv
module bsc_pipe import bsc_pkg::*; (
    input  logic                  aclk,
    input  logic [NUM_STAGES-1:0] stage_en,
    input  logic [RAW_W-1:0]      raw_pressure,
    input  logic [RAW_W-1:0]      raw_temperature,
    input  cal_t                  cal,
    output res_t                  res
);

    // stage 0: dT
    logic        [RAW_W-1:0] d1_s0_reg;
    logic signed [24:0]      dt_next, dt_s0_reg;

    // stage 1: products of dT
    logic        [RAW_W-1:0] d1_s1_reg;
    logic signed [41:0]      p_tdev_next, p_tdev_s1_reg;
    logic signed [41:0]      p_off_next, p_off_s1_reg;
    logic signed [41:0]      p_sens_next, p_sens_s1_reg;
    logic signed [49:0]      p_dd_next, p_dd_s1_reg;

    // stage 2: first-order terms
    logic        [RAW_W-1:0] d1_s2_reg;
    logic signed [17:0]      tdev_next, tdev_s2_reg;
    logic signed [18:0]      temp1_next, temp1_s2_reg;
    logic signed [18:0]      m_next, m_s2_reg;
    logic signed [34:0]      p_off_sh;
    logic signed [33:0]      p_sens_sh;
    logic signed [35:0]      off1_next, off1_s2_reg, off1_s3_reg, off1_s4_reg;
    logic signed [34:0]      sens1_next, sens1_s2_reg, sens1_s3_reg, sens1_s4_reg;
    logic        [16:0]      t2_next, t2_s2_reg;
    logic                    lo_s2_reg, vlo_s2_reg;

    // stage 3: squares, corrected temperature
    logic        [RAW_W-1:0] d1_s3_reg;
    logic signed [35:0]      sq_full;
    logic signed [37:0]      msq_full;
    logic        [33:0]      sq_s3_reg;
    logic        [35:0]      msq_s3_reg;
    logic signed [19:0]      temp2_next, temp2_s3_reg, temp2_s4_reg, temp2_s5_reg;
    logic signed [19:0]      temp2_s6_reg, temp2_s7_reg;
    logic                    lo_s3_reg, vlo_s3_reg;

    // stage 4: second-order offset and sensitivity terms
    logic        [RAW_W-1:0] d1_s4_reg;
    logic        [39:0]      sq61, msq15;
    logic        [40:0]      off2_next, off2_s4_reg;
    logic        [39:0]      sens2_next, sens2_s4_reg;
    logic                    lo_s4_reg;

    // stage 5: corrected offset and sensitivity
    logic        [RAW_W-1:0] d1_s5_reg;
    logic signed [42:0]      off_c_next, off_c_s5_reg, off_c_s6_reg;
    logic signed [41:0]      sens_c_next, sens_c_s5_reg;

    // stage 6: split D1 * SENS
    logic signed [24:0]      d1_sgn;
    logic signed [20:0]      sens_hi;
    logic        [44:0]      pl_next, pl_s6_reg;
    logic signed [45:0]      ph_next, ph_s6_reg;

    // stage 7: pressure before the final shift
    logic signed [45:0]      q_next, q_s7_reg;

    // stage 8: offset, window, output
    logic signed [30:0]      q_sh;
    logic signed [31:0]      pres;
    logic                    ok;
    res_t                    res_next, res_reg;

    always_comb begin
        dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.c5, 8'h00});

        p_tdev_next = dt_s0_reg * $signed({1'b0, cal.c6});
        p_off_next  = dt_s0_reg * $signed({1'b0, cal.c4});
        p_sens_next = dt_s0_reg * $signed({1'b0, cal.c3});
        p_dd_next   = dt_s0_reg * dt_s0_reg;

        // floor shifts are bit selects; the dropped top bits are sign copies
        tdev_next  = p_tdev_s1_reg[40:23];
        temp1_next = 19'(tdev_next) + 19'(T_REF_CENTI);
        m_next     = 19'(tdev_next) + 19'(T_REF_CENTI - T_VLO_CENTI);
        p_off_sh   = p_off_s1_reg[40:6];
        p_sens_sh  = p_sens_s1_reg[40:7];
        off1_next  = $signed({3'b000, cal.c2, 17'h0}) + 36'(p_off_sh);
        sens1_next = $signed({3'b000, cal.c1, 16'h0}) + 35'(p_sens_sh);
        t2_next    = p_dd_s1_reg[47:31];

        sq_full    = tdev_s2_reg * tdev_s2_reg;
        msq_full   = m_s2_reg * m_s2_reg;
        temp2_next = 20'(temp1_s2_reg) + 20'(cal.t_off)
                   - (lo_s2_reg ? 20'($signed({1'b0, t2_s2_reg})) : 20'sd0);

        sq61       = 40'(sq_s3_reg) * 40'(OFF2_SQ_GAIN);
        msq15      = 40'(msq_s3_reg) * 40'(OFF2_VLO_GAIN);
        off2_next  = 41'(sq61 >> OFF2_SQ_SHIFT) + (vlo_s3_reg ? 41'(msq15) : 41'd0);
        sens2_next = 40'(sq_s3_reg) * 40'(SENS2_SQ_GAIN)
                   + (vlo_s3_reg ? 40'(msq_s3_reg) * 40'(SENS2_VLO_GAIN) : 40'd0);

        off_c_next  = 43'(off1_s4_reg) - (lo_s4_reg ? $signed({2'b00, off2_s4_reg}) : 43'sd0);
        sens_c_next = 42'(sens1_s4_reg) - (lo_s4_reg ? $signed({2'b00, sens2_s4_reg}) : 42'sd0);

        // D1 * SENS >> 21 = D1 * (SENS >> 21) + (D1 * SENS[20:0]) >> 21
        d1_sgn  = $signed({1'b0, d1_s5_reg});
        sens_hi = sens_c_s5_reg[41:21];
        pl_next = 45'(d1_s5_reg) * 45'(sens_c_s5_reg[20:0]);
        ph_next = d1_sgn * sens_hi;

        q_next = ph_s6_reg + $signed({22'h0, pl_s6_reg[44:21]}) - 46'(off_c_s6_reg);

        q_sh = q_s7_reg[45:15];
        pres = 32'(q_sh) + 32'(cal.p_off);
        ok   = (temp2_s7_reg > 20'(T_MIN_CENTI)) && (temp2_s7_reg < 20'(T_MAX_CENTI))
            && (pres > 32'(P_MIN_CENTI)) && (pres < 32'(P_MAX_CENTI));
        res_next.temp_centi     = ok ? temp2_s7_reg[TEMP_OUT_W-1:0] : '0;
        res_next.pressure_centi = ok ? pres[PRES_OUT_W-1:0] : '0;
        res_next.in_range       = ok;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            d1_s0_reg <= raw_pressure;
            dt_s0_reg <= dt_next;
        end
        if (stage_en[1]) begin
            d1_s1_reg     <= d1_s0_reg;
            p_tdev_s1_reg <= p_tdev_next;
            p_off_s1_reg  <= p_off_next;
            p_sens_s1_reg <= p_sens_next;
            p_dd_s1_reg   <= p_dd_next;
        end
        if (stage_en[2]) begin
            d1_s2_reg    <= d1_s1_reg;
            tdev_s2_reg  <= tdev_next;
            temp1_s2_reg <= temp1_next;
            m_s2_reg     <= m_next;
            lo_s2_reg    <= tdev_next[17];
            vlo_s2_reg   <= m_next[18];
            off1_s2_reg  <= off1_next;
            sens1_s2_reg <= sens1_next;
            t2_s2_reg    <= t2_next;
        end
        if (stage_en[3]) begin
            d1_s3_reg    <= d1_s2_reg;
            sq_s3_reg    <= sq_full[33:0];
            msq_s3_reg   <= msq_full[35:0];
            temp2_s3_reg <= temp2_next;
            off1_s3_reg  <= off1_s2_reg;
            sens1_s3_reg <= sens1_s2_reg;
            lo_s3_reg    <= lo_s2_reg;
            vlo_s3_reg   <= vlo_s2_reg;
        end
        if (stage_en[4]) begin
            d1_s4_reg    <= d1_s3_reg;
            off2_s4_reg  <= off2_next;
            sens2_s4_reg <= sens2_next;
            off1_s4_reg  <= off1_s3_reg;
            sens1_s4_reg <= sens1_s3_reg;
            lo_s4_reg    <= lo_s3_reg;
            temp2_s4_reg <= temp2_s3_reg;
        end
        if (stage_en[5]) begin
            d1_s5_reg     <= d1_s4_reg;
            off_c_s5_reg  <= off_c_next;
            sens_c_s5_reg <= sens_c_next;
            temp2_s5_reg  <= temp2_s4_reg;
        end
        if (stage_en[6]) begin
            pl_s6_reg    <= pl_next;
            ph_s6_reg    <= ph_next;
            off_c_s6_reg <= off_c_s5_reg;
            temp2_s6_reg <= temp2_s5_reg;
        end
        if (stage_en[7]) begin
            q_s7_reg     <= q_next;
            temp2_s7_reg <= temp2_s6_reg;
        end
        if (stage_en[8]) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

>>> rtl/baro_sensor_compensation_top.sv
// Channel   | Direction | Beat contents
// ----------+-----------+-------------------------------------------------------------
// s_axis    | in        | tdata[47:0]: raw_pressure [23:0], raw_temperature [47:24]
// m_axis    | out       | tdata[31:0]: temp_centi [13:0], pressure_centi [30:14], 0;
//           |           | tuser: in_range
// cfg       | in        | cfg_wr_en, cfg_index (register 0..7), cfg_data (16 bit)
//
// One beat per cycle sustained while m_axis_tready stays high; a taken beat moves
// through the registers of stages 0 to 8, and the last of them drives m_axis.
// Nine register stages; the depth is set by the 25x17 dT products, the squares
// and the split 24x42 D1*SENS product, each followed by a register.
// aresetn is synchronous, active low: it empties the pipeline and loads the
// calibration registers with their reset values (all 0, pressure offset 170).
// A stall on m_axis holds only the full stages; empty stages keep filling.
`include "baro_sensor_compensation_top_defines.svh"

module baro_sensor_compensation_top import bsc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [47:0]          s_axis_tdata,  // raw_pressure, raw_temperature

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,  // temp_centi, pressure_centi, zero pad
    output logic                 m_axis_tuser,  // in_range

    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CAL_W-1:0]     cfg_data
);

    cal_t                  cal_reg;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] stage_ready;
    res_t                  res;

    // Calibration and offset registers; the user must write them only while the pipeline is idle (not enforced here).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg.c1    <= '0;
            cal_reg.c2    <= '0;
            cal_reg.c3    <= '0;
            cal_reg.c4    <= '0;
            cal_reg.c5    <= '0;
            cal_reg.c6    <= '0;
            cal_reg.t_off <= '0;
            cal_reg.p_off <= CAL_W'(PRES_OFFSET_RESET);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_C1_SENS:     cal_reg.c1    <= cfg_data;
                REG_C2_OFF:      cal_reg.c2    <= cfg_data;
                REG_C3_TCS:      cal_reg.c3    <= cfg_data;
                REG_C4_TCO:      cal_reg.c4    <= cfg_data;
                REG_C5_TREF:     cal_reg.c5    <= cfg_data;
                REG_C6_TEMPSENS: cal_reg.c6    <= cfg_data;
                REG_TEMP_OFFSET: cal_reg.t_off <= cfg_data;
                REG_PRES_OFFSET: cal_reg.p_off <= cfg_data;
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or its successor loads in the same cycle;
    // the last stage is the output register and drains on a taken beat.
    always_comb begin
        stage_ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
        valid_next[0] = s_axis_tvalid;
        for (int k = 1; k < NUM_STAGES; k++) begin
            valid_next[k] = valid_reg[k-1];
        end
    end

    // Advance valid bits alongside the payload; hold a stage that cannot load.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (stage_ready[k]) begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    bsc_pipe u_pipe (
        .aclk            (aclk),
        .stage_en        (stage_ready),
        .raw_pressure    (s_axis_tdata[23:0]),
        .raw_temperature (s_axis_tdata[47:24]),
        .cal             (cal_reg),
        .res             (res)
    );

    assign s_axis_tready = stage_ready[0];
    assign m_axis_tvalid = valid_reg[NUM_STAGES-1];
    assign m_axis_tdata  = {1'b0, res.pressure_centi, res.temp_centi};
    assign m_axis_tuser  = res.in_range;

    // An out-of-window result carries zero values.
    `BSC_ASSERT_IMPLY(a_out_of_range_zero, aclk, aresetn,
        m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 32'h0,
        "out-of-range beat carries nonzero data")
    // An in-window result keeps the temperature strictly inside the window.
    `BSC_ASSERT_IMPLY(a_temp_window, aclk, aresetn, m_axis_tvalid && m_axis_tuser,
        (res.temp_centi > 14'(T_MIN_CENTI)) && (res.temp_centi < 14'(T_MAX_CENTI)),
        "temperature outside window flagged in range")
    // An in-window result keeps the pressure strictly inside the window.
    `BSC_ASSERT_IMPLY(a_pres_window, aclk, aresetn, m_axis_tvalid && m_axis_tuser,
        (res.pressure_centi > 17'(P_MIN_CENTI)) && (res.pressure_centi < 17'(P_MAX_CENTI)),
        "pressure outside window flagged in range")
    // A full pipeline with a stalled output takes no new beat.
    `BSC_ASSERT_IMPLY(a_full_stall, aclk, aresetn,
        (&valid_reg) && !m_axis_tready, !s_axis_tready,
        "beat taken into a full stalled pipeline")
    // A taken beat occupies the first stage in the next cycle.
    `BSC_ASSERT_NEXT(a_enter_stage0, aclk, aresetn,
        s_axis_tvalid && s_axis_tready, valid_reg[0],
        "taken beat lost at pipeline entry")

endmodule

>>> tb/tb_baro_sensor_compensation_top.sv
module tb_baro_sensor_compensation_top import bsc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // Compensation constants, temperatures in 0.01 C, pressures in 0.01 hPa
    localparam longint TREF_CENTI   = 2000;
    localparam longint TCOLD_CENTI  = -1500;
    localparam longint TLOW_CENTI   = -3000;
    localparam longint THIGH_CENTI  = 8000;
    localparam longint PLOW_CENTI   = 30000;
    localparam longint PHIGH_CENTI  = 120000;

    // Generous ceiling on the run: a few hundred beats, with the receiver stalling 82%
    // of the time in part of the run.
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int RANDOM_PHASES    = 6;
    localparam int BEATS_PER_PHASE  = 67;

    // Every out-of-window reading comes back all zero.
    localparam res_t DARK_READING = '0;

    // One directed beat: calibration set to run it under, raw D1 and D2, and
    // the reading typed in where it is obvious (otherwise computed).
    typedef struct packed {
        logic [2:0]  sel;
        logic [23:0] d1;
        logic [23:0] d2;
        logic        typed;
        res_t        want;
    } dir_row_t;

    // Calibration sets used by the directed table. Set 0 is the reset state.
    localparam cal_t CAL_SETS [5] = '{
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'sd0, 16'sd170},
        '{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165,
          16'sd0, 16'sd0},
        '{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165,
          -16'sd250, 16'sh8000},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          16'sh7FFF, 16'sh7FFF},
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'sh8000, 16'sh8000}
    };

    localparam dir_row_t DIR_ROWS [22] = '{
        // Reset calibration: pressure sits at the offset alone, far below
        // the window, so every reading is dark.
        '{3'd0, 24'd0,        24'd0,        1'b1, DARK_READING},
        '{3'd0, 24'hFFFFFF,   24'hFFFFFF,   1'b1, DARK_READING},
        '{3'd0, 24'hFFFFFF,   24'd0,        1'b1, DARK_READING},
        '{3'd0, 24'd0,        24'hFFFFFF,   1'b1, DARK_READING},
        '{3'd0, 24'hAAAAAA,   24'h555555,   1'b1, DARK_READING},
        // Typical calibration: nominal, dT of zero and minus one (second
        // order just kicks in), cold, very cold, too cold, too hot
        '{3'd1, 24'd6465444,  24'd8077636,  1'b0, DARK_READING},
        '{3'd1, 24'd6465444,  24'd8077568,  1'b0, DARK_READING},
        '{3'd1, 24'd6465444,  24'd8077567,  1'b0, DARK_READING},
        '{3'd1, 24'd6000000,  24'd7500000,  1'b0, DARK_READING},
        '{3'd1, 24'd5500000,  24'd6900000,  1'b0, DARK_READING},
        '{3'd1, 24'd5500000,  24'd6500000,  1'b0, DARK_READING},
        '{3'd1, 24'd6500000,  24'd9900000,  1'b0, DARK_READING},
        // D1 of zero leaves only -OFF: deeply negative pressure
        '{3'd1, 24'd0,        24'd8077636,  1'b1, DARK_READING},
        '{3'd1, 24'hFFFFFF,   24'd8077636,  1'b0, DARK_READING},
        '{3'd1, 24'd4500000,  24'd8077636,  1'b0, DARK_READING},
        '{3'd1, 24'd7000000,  24'd8077636,  1'b0, DARK_READING},
        // Negative offsets, largest negative pressure offset
        '{3'd2, 24'd6465444,  24'd8077636,  1'b0, DARK_READING},
        '{3'd2, 24'd6900000,  24'd7000000,  1'b0, DARK_READING},
        // All calibration words at full scale, largest positive offsets
        '{3'd3, 24'hFFFFFF,   24'hFFFFFF,   1'b0, DARK_READING},
        '{3'd3, 24'd0,        24'd0,        1'b0, DARK_READING},
        '{3'd3, 24'h800000,   24'h7FFFFF,   1'b0, DARK_READING},
        // Zero words, temperature offset drags T to about -307 C
        '{3'd4, 24'd123456,   24'd654321,   1'b1, DARK_READING}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [47:0]          s_axis_tdata = '0;   // raw_pressure [23:0], raw_temperature [47:24]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [31:0]          m_axis_tdata;        // temp_centi [13:0], pressure_centi [30:14], pad
    logic                 m_axis_tuser;        // in_range
    logic                 cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [CAL_W-1:0]     cfg_data = '0;

    cal_t        active_cal = CAL_SETS[0];   // what the block holds right now
    res_t        expected_readings [$];
    res_t        want_reading;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    int          errors = 0;
    int          n_checked = 0;
    int          n_window = 0;
    int          n_cal = 0;
    int unsigned cycle_count = 0;

    baro_sensor_compensation_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 aclk = ~aclk;

    // Compensated reading for one D1/D2 pair under calibration c, 64-bit
    // signed throughout, with floor shifts.
    function automatic res_t compensate(input cal_t c, input logic [23:0] d1,
                                        input logic [23:0] d2);
        longint d1v, d2v, c1, c2, c3, c4, c5, c6, toff, poff;
        longint dt, tdev, t_c, off, sens, t2, sq, off2, sens2, m, p_c;
        res_t   r;
        d1v  = longint'(d1);
        d2v  = longint'(d2);
        c1   = longint'(c.c1);
        c2   = longint'(c.c2);
        c3   = longint'(c.c3);
        c4   = longint'(c.c4);
        c5   = longint'(c.c5);
        c6   = longint'(c.c6);
        toff = longint'($signed(c.t_off));
        poff = longint'($signed(c.p_off));

        dt   = d2v - c5 * 256;
        tdev = (dt * c6) >>> 23;
        t_c  = tdev + TREF_CENTI;
        off  = c2 * 131072 + ((c4 * dt) >>> 6);
        sens = c1 * 65536 + ((c3 * dt) >>> 7);

        // Second-order correction below 20 C, extra terms below -15 C
        if (t_c < TREF_CENTI) begin
            t2    = (dt * dt) >>> 31;
            sq    = tdev * tdev;
            off2  = (61 * sq) >>> 4;
            sens2 = 2 * sq;
            if (t_c < TCOLD_CENTI) begin
                m     = t_c - TCOLD_CENTI;
                off2  = off2 + 15 * m * m;
                sens2 = sens2 + 8 * m * m;
            end
            t_c  = t_c - t2;
            off  = off - off2;
            sens = sens - sens2;
        end

        t_c = t_c + toff;
        p_c = (((d1v * sens) >>> 21) - off) >>> 15;
        p_c = p_c + poff;

        if (t_c > TLOW_CENTI && t_c < THIGH_CENTI && p_c > PLOW_CENTI && p_c < PHIGH_CENTI) begin
            r.temp_centi     = t_c[TEMP_OUT_W-1:0];
            r.pressure_centi = p_c[PRES_OUT_W-1:0];
            r.in_range       = 1'b1;
        end else begin
            r = DARK_READING;
        end
        return r;
    endfunction

    // Calibration for a random phase: near a typical part, full scale
    // corners, or any 16-bit words at all.
    function automatic cal_t random_cal(input int flavor);
        cal_t c;
        int   r;
        case (flavor)
            0: begin
                c.c1 = 16'($urandom_range(40000, 52000));
                c.c2 = 16'($urandom_range(38000, 50000));
                c.c3 = 16'($urandom_range(24000, 34000));
                c.c4 = 16'($urandom_range(22000, 33000));
                c.c5 = 16'($urandom_range(28000, 35000));
                c.c6 = 16'($urandom_range(25000, 31000));
                r = int'($urandom_range(0, 600));
                c.t_off = 16'(r - 300);
                r = int'($urandom_range(0, 4000));
                c.p_off = 16'(r - 2000);
            end
            1: begin
                c = cal_t'({$urandom, $urandom, $urandom, $urandom});
            end
            default: begin
                c.c1 = 16'hFFFF;
                c.c2 = 16'h0000;
                c.c3 = 16'hFFFF;
                c.c4 = 16'h0000;
                c.c5 = 16'hFFFF;
                c.c6 = 16'hFFFF;
                c.t_off = 16'sh8000;
                c.p_off = 16'sh7FFF;
            end
        endcase
        return c;
    endfunction

    // mode 0: sender light, receiver heavy; mode 1: swapped; mode 2: no stalls
    task automatic set_idle(input int mode);
        case (mode)
            0:       begin src_idle_pct = 28; snk_idle_pct = 82; end
            1:       begin src_idle_pct = 82; snk_idle_pct = 28; end
            default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
        endcase
    endtask

    // Offer one beat, holding it until the block takes it; log the reading
    // it must produce at the edge where it is taken.
    task automatic send_reading(input logic [23:0] d1, input logic [23:0] d2,
                                input logic typed, input res_t want);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {d2, d1};
        do @(posedge aclk); while (!s_axis_tready);
        expected_readings.push_back(typed ? want : compensate(active_cal, d1, d2));
    endtask

    // Drop valid and hold until every reading in flight is back and the
    // pipeline has run empty.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge aclk);
        repeat (NUM_STAGES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CAL_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
    endtask

    // Load a full calibration set; call only with the block idle.
    task automatic program_cal(input cal_t c);
        write_reg(REG_C1_SENS,     c.c1);
        write_reg(REG_C2_OFF,      c.c2);
        write_reg(REG_C3_TCS,      c.c3);
        write_reg(REG_C4_TCO,      c.c4);
        write_reg(REG_C5_TREF,     c.c5);
        write_reg(REG_C6_TEMPSENS, c.c6);
        write_reg(REG_TEMP_OFFSET, c.t_off);
        write_reg(REG_PRES_OFFSET, c.p_off);
        cfg_wr_en  <= 1'b0;
        active_cal = c;
        n_cal++;
    endtask

    // Stimulus: directed table first, then random phases
    initial begin
        int          cur_sel;
        int          flavor;
        int          t;
        logic [23:0] d1;
        logic [23:0] d2;

        // Hold reset at the start, then release it once for good
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: walk the table, reloading calibration when a row
        // asks for a different set. Set 0 is what reset leaves behind.
        set_idle(0);
        cur_sel = 0;
        foreach (DIR_ROWS[i]) begin
            if (int'(DIR_ROWS[i].sel) != cur_sel) begin
                drain();
                cur_sel = int'(DIR_ROWS[i].sel);
                program_cal(CAL_SETS[cur_sel]);
            end
            send_reading(DIR_ROWS[i].d1, DIR_ROWS[i].d2, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        end

        // Random part: two phases per stall mix, a fresh calibration each.
        // Most beats are plausible conversions around the reference
        // temperature so the window and both corrections are exercised;
        // the rest is full-range noise.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_idle(ph / 2);
            drain();
            flavor = (ph == 1) ? 2 : (ph == 3) ? 1 : 0;
            program_cal(random_cal(flavor));
            for (int k = 0; k < BEATS_PER_PHASE; k++) begin
                if ($urandom_range(0, 99) < 75) begin
                    d1 = 24'($urandom_range(4400000, 7000000));
                    t  = int'(active_cal.c5) * 256
                       + int'($urandom_range(0, 3600000)) - 1700000;
                    if (t < 0)
                        t = 0;
                    else if (t > 16777215)
                        t = 16777215;
                    d2 = t[23:0];
                end else begin
                    d1 = 24'($urandom_range(0, 16777215));
                    d2 = 24'($urandom_range(0, 16777215));
                end
                send_reading(d1, d2, 1'b0, DARK_READING);
            end
        end

        // Let the last readings come home and the pipeline run empty, then report
        drain();
        repeat (NUM_STAGES) @(posedge aclk);

        $display("Checked %0d readings, %0d of them inside the valid window,",
                 n_checked, n_window);
        $display("under %0d calibration loads, with stalls on either side, at full rate,",
                 n_cal);
        $display("and across cold and hot corrections.");
        if (errors == 0) begin
            $display("PASS baro_sensor_compensation_top");
        end else begin
            $display("FAIL baro_sensor_compensation_top");
        end
        $finish;
    end

    // Receiver: stall at random, and compare each taken beat against the
    // oldest reading still owed.
    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_readings.size() == 0) begin
                errors++;
                $display("%0t: unexpected reading, temp %0d pres %0d in_range %0b", $time,
                         $signed(m_axis_tdata[13:0]), m_axis_tdata[30:14], m_axis_tuser);
            end else begin
                want_reading = expected_readings.pop_front();
                n_checked++;
                if (want_reading.in_range)
                    n_window++;
                if (m_axis_tdata[13:0] !== want_reading.temp_centi ||
                    m_axis_tdata[30:14] !== want_reading.pressure_centi ||
                    m_axis_tuser !== want_reading.in_range ||
                    m_axis_tdata[31] !== 1'b0) begin
                    errors++;
                    $display("%0t: mismatch, expected temp %0d pres %0d in_range %0b pad 0,",
                             $time, $signed(want_reading.temp_centi),
                             want_reading.pressure_centi, want_reading.in_range);
                    $display("    got temp %0d pres %0d in_range %0b pad %0b",
                             $signed(m_axis_tdata[13:0]), m_axis_tdata[30:14],
                             m_axis_tuser, m_axis_tdata[31]);
                end
            end
        end
    end

    // Watchdog: advance the cycle count and stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL baro_sensor_compensation_top");
            $finish;
        end
    end

endmodule

>>> baro_sensor_compensation_top.f
+incdir+rtl
rtl/bsc_pkg.sv
rtl/bsc_pipe.sv
rtl/baro_sensor_compensation_top.sv
tb/tb_baro_sensor_compensation_top.sv
